FILE: hdl/lpm_pkg.sv
// Shared definitions for the longest-prefix-match router.
// Holds parameter defaults, result status codes and the controller/datapath
// command and status bundles. No dependencies.
package lpm_pkg;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF    = 32;
  localparam int NUM_INTERFACES_DEF = 16;

  // Result status codes
  localparam logic [2:0] ST_ADDED        = 3'd0;
  localparam logic [2:0] ST_FORWARDED    = 3'd1;
  localparam logic [2:0] ST_DROP_TTL     = 3'd2;
  localparam logic [2:0] ST_DROP_NOROUTE = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  // Field widths of one beat
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 48;

  // One input item, unpacked
  typedef struct packed {
    logic        kind;
    logic [31:0] dest_prefix;
    logic [5:0]  mask_len;
    logic        has_next_hop;
    logic [31:0] next_hop_addr;
    logic [3:0]  route_interface;
    logic [31:0] dst_addr;
    logic [7:0]  ttl_in;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;      // latch the accepted item, reset scan state
    logic store_route;  // store the latched route if the table has room
    logic scan_step;    // read the next table entry
    logic finish;       // load the result register
  } lpm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_add;     // latched item is an add
    logic quick;      // datagram resolved without a scan (ttl drop or empty table)
    logic scan_last;  // current read pointer is the last stored entry
    logic out_busy;   // result register holds a beat that is not taken
  } lpm_stat_t;

endpackage

FILE: hdl/lpm_ctrl.sv
// Controller for the longest-prefix-match router.
// Sequences accept, table write, entry scan and result load.
// Depends on lpm_pkg.
module lpm_ctrl
  import lpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  lpm_stat_t stat,
  output lpm_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_FLUSH    = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_add || stat.quick) begin
          if (!stat.out_busy) begin
            cmd.store_route = stat.is_add;
            cmd.finish      = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_FLUSH;
        end
      end
      // last read data is compared here
      S_FLUSH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/lpm_datapath.sv
// Datapath for the longest-prefix-match router.
// Holds the route table memory, the scan pointer, the best-match tracker
// and the result register. Depends on lpm_pkg.
module lpm_datapath
  import lpm_pkg::*;
#(
  parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
  parameter int NUM_INTERFACES = NUM_INTERFACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 item,
  input  lpm_cmd_t              cmd,
  output lpm_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        has_hop;
    logic [31:0] hop_addr;
    logic [3:0]  ifc;
  } entry_t;

  entry_t          table_mem [TABLE_DEPTH];
  entry_t          rd_entry;
  logic            rd_valid;
  item_t           cur;
  logic [CNT_W-1:0] route_count;
  logic [CNT_W-1:0] last_idx;
  logic [IDX_W-1:0] ptr;
  logic            full;

  logic            found;
  logic [5:0]      best_len;
  logic [3:0]      best_ifc;
  logic            best_has_hop;
  logic [31:0]     best_hop;

  // Interface index reduced modulo the interface count
  logic [3:0] ifc_mod [16];
  for (genvar g = 0; g < 16; g++) begin : g_ifc_mod
    assign ifc_mod[g] = 4'(g % NUM_INTERFACES);
  end

  // Route as it goes into the table
  entry_t new_entry;
  always_comb begin
    new_entry.prefix   = cur.dest_prefix;
    new_entry.len      = (cur.mask_len > 6'd32) ? 6'd32 : cur.mask_len;
    new_entry.has_hop  = cur.has_next_hop;
    new_entry.hop_addr = cur.next_hop_addr;
    new_entry.ifc      = ifc_mod[cur.route_interface];
  end

  assign full     = (route_count == CNT_W'(TABLE_DEPTH));
  assign last_idx = route_count - CNT_W'(1);

  // Status to the controller
  assign stat.is_add    = ~cur.kind;
  assign stat.quick     = (cur.ttl_in[7:1] == 7'd0) || (route_count == '0);
  assign stat.scan_last = (ptr == last_idx[IDX_W-1:0]);
  assign stat.out_busy  = out_valid && !out_ready;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
  end

  // Route count
  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
    end else if (cmd.store_route && !full) begin
      route_count <= route_count + CNT_W'(1);
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_route && !full) begin
      table_mem[route_count[IDX_W-1:0]] <= new_entry;
    end
    if (cmd.scan_step) begin
      rd_entry <= table_mem[ptr];
    end
  end

  // Scan pointer and read-data valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.capture) begin
        ptr <= '0;
      end else if (cmd.scan_step) begin
        ptr <= ptr + IDX_W'(1);
      end
    end
  end

  // Prefix compare; strictly longer wins so the earliest route keeps a tie
  logic [31:0] mask;
  logic        hit;
  logic        take;
  always_comb begin
    mask = ~(32'hFFFF_FFFF >> rd_entry.len);
    hit  = (((cur.dst_addr ^ rd_entry.prefix) & mask) == 32'd0);
    take = rd_valid && hit && (!found || (rd_entry.len > best_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.capture) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_len     <= rd_entry.len;
      best_ifc     <= rd_entry.ifc;
      best_has_hop <= rd_entry.has_hop;
      best_hop     <= rd_entry.hop_addr;
    end
  end

  // Result selection
  logic [2:0]  res_status;
  logic [3:0]  res_ifc;
  logic [31:0] res_hop;
  logic [7:0]  res_ttl;
  always_comb begin
    res_status = ST_ADDED;
    res_ifc    = 4'd0;
    res_hop    = 32'd0;
    res_ttl    = 8'd0;
    if (!cur.kind) begin
      res_status = full ? ST_FULL : ST_ADDED;
    end else if (cur.ttl_in[7:1] == 7'd0) begin
      res_status = ST_DROP_TTL;
    end else if (!found) begin
      res_status = ST_DROP_NOROUTE;
    end else begin
      res_status = ST_FORWARDED;
      res_ifc    = best_ifc;
      res_hop    = best_has_hop ? best_hop : cur.dst_addr;
      res_ttl    = cur.ttl_in - 8'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {1'b0, res_ttl, res_hop, res_ifc, res_status};
    end
  end

endmodule

FILE: hdl/longest_prefix_match_router.sv
// IPv4 longest-prefix-match router, top level.
// Input beat (s_*) is either a route add (tuser 0) or a datagram (tuser 1).
// Each beat yields exactly one result beat on m_*.
// An add or a datagram dropped for TTL (or with an empty table) skips the
// scan: its result is loaded straight from dispatch. A looked-up datagram
// runs the entry scan, which reads one table entry
// per cycle from the single read port of the route memory; a flush state
// then compares the last entry. The next beat is taken after the result is
// loaded. Ties on prefix length go to the earliest added route.
// The result sits in an output register: a new beat is accepted while it
// waits, but that beat's result is held back until m_tready takes the old
// one. Reset empties the table (route count to zero) and clears the
// output; the entries themselves are not cleared and need no sweep.
// Depends on lpm_pkg, lpm_ctrl, lpm_datapath.
module longest_prefix_match_router
  import lpm_pkg::*;
#(
  parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
  parameter int NUM_INTERFACES = NUM_INTERFACES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // dest_prefix[31:0], mask_len[37:32], has_next_hop[38],
  // next_hop_addr[70:39], route_interface[74:71], dst_addr[106:75],
  // ttl_in[114:107], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[2:0], out_interface[6:3], hop_addr[38:7], ttl_out[46:39], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  item_t     item;
  lpm_cmd_t  cmd;
  lpm_stat_t stat;

  // Unpack the input beat
  always_comb begin
    item.kind            = s_tuser;
    item.dest_prefix     = s_tdata[31:0];
    item.mask_len        = s_tdata[37:32];
    item.has_next_hop    = s_tdata[38];
    item.next_hop_addr   = s_tdata[70:39];
    item.route_interface = s_tdata[74:71];
    item.dst_addr        = s_tdata[106:75];
    item.ttl_in          = s_tdata[114:107];
  end

  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpm_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .NUM_INTERFACES (NUM_INTERFACES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

FILE: verif/longest_prefix_match_router_tb.sv
// Self-checking testbench for the longest-prefix-match router.
// Sends route adds and datagrams, predicts every result in a small scoreboard
// class and checks each result beat field by field. Needs lpm_pkg and the RTL.
`timescale 1ns / 100ps

module longest_prefix_match_router_tb;
  import lpm_pkg::*;

  localparam int  TABLE_DEPTH    = TABLE_DEPTH_DEF;
  localparam int  NUM_INTERFACES = NUM_INTERFACES_DEF;
  localparam bit  KIND_ADD       = 1'b0;
  localparam bit  KIND_DATAGRAM  = 1'b1;
  localparam int  SIDE_SEND      = 0;
  localparam int  SIDE_RECV      = 1;
  localparam int  RANDOM_ITEMS   = 627;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  HOLD_AFTER     = 300;
  localparam int  DRAIN_CYCLES   = 50;
  localparam int  MAX_REPORTS    = 10;

  typedef struct {
    bit [2:0]  status;
    bit [3:0]  out_interface;
    bit [31:0] hop_addr;
    bit [7:0]  ttl_out;
  } fwd_result_t;

  // Route table mirror plus the queue of forwarding results still owed
  class route_predictor;
    bit [31:0]   prefix_tab [TABLE_DEPTH];
    bit [5:0]    length_tab [TABLE_DEPTH];
    bit          has_hop_tab [TABLE_DEPTH];
    bit [31:0]   hop_tab [TABLE_DEPTH];
    bit [3:0]    ifc_tab [TABLE_DEPTH];
    int          route_count;
    fwd_result_t owed [$];
    int          mismatches;

    function new();
      route_count = 0;
      mismatches  = 0;
    endfunction

    function bit [31:0] prefix_mask(input bit [5:0] len);
      if (len == 0) return 32'h0;
      if (len >= 32) return 32'hFFFF_FFFF;
      return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Work out the result of one accepted beat and queue it
    function void accept_item(input item_t it);
      fwd_result_t r;
      bit          found;
      bit [5:0]    best_len;
      int          best;
      r = '{ST_ADDED, 4'd0, 32'd0, 8'd0};
      found = 1'b0;
      best_len = '0;
      best = 0;
      if (it.kind == KIND_ADD) begin
        if (route_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          prefix_tab[route_count]  = it.dest_prefix;
          length_tab[route_count]  = (it.mask_len > 32) ? 6'd32 : it.mask_len;
          has_hop_tab[route_count] = it.has_next_hop;
          hop_tab[route_count]     = it.next_hop_addr;
          ifc_tab[route_count]     = 4'(it.route_interface % NUM_INTERFACES);
          route_count++;
          r.status = ST_ADDED;
        end
      end else if (it.ttl_in <= 8'd1) begin
        r.status = ST_DROP_TTL;
      end else begin
        // longest match; strict compare keeps the earliest route on a tie
        for (int i = 0; i < route_count; i++) begin
          if (((it.dst_addr ^ prefix_tab[i]) & prefix_mask(length_tab[i])) == 32'h0 &&
              (!found || length_tab[i] > best_len)) begin
            found = 1'b1;
            best_len = length_tab[i];
            best = i;
          end
        end
        if (!found) begin
          r.status = ST_DROP_NOROUTE;
        end else begin
          r.status        = ST_FORWARDED;
          r.out_interface = ifc_tab[best];
          r.hop_addr      = has_hop_tab[best] ? hop_tab[best] : it.dst_addr;
          r.ttl_out       = it.ttl_in - 8'd1;
        end
      end
      owed = {owed, r};
    endfunction

    // Compare one result beat with the oldest owed result
    function void check_result(input logic [OUT_DATA_W-1:0] beat);
      fwd_result_t e;
      fwd_result_t a;
      a.status        = beat[2:0];
      a.out_interface = beat[6:3];
      a.hop_addr      = beat[38:7];
      a.ttl_out       = beat[46:39];
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result beat status %0d ifc %0d hop %h ttl %0d",
                   $time, a.status, a.out_interface, a.hop_addr, a.ttl_out);
        return;
      end
      e = owed.pop_front();
      if (a.status !== e.status || a.out_interface !== e.out_interface ||
          a.hop_addr !== e.hop_addr || a.ttl_out !== e.ttl_out) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch exp status %0d ifc %0d hop %h ttl %0d, got %0d %0d %h %0d",
                   $time, e.status, e.out_interface, e.hop_addr, e.ttl_out,
                   a.status, a.out_interface, a.hop_addr, a.ttl_out);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  route_predictor book;
  int items_sent = 0;
  int calm [2] = '{0, 0};

  longest_prefix_match_router u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Idle length: mostly none or short, a few long, now and then a calm stretch
  function automatic int pick_gap(input int side);
    int r;
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat from a falling edge, hold until taken, then idle for a random gap, often none
  task automatic drive_item(input item_t it);
    logic [IN_DATA_W-1:0] beat;
    int gap;
    beat = '0;
    beat[31:0]    = it.dest_prefix;
    beat[37:32]   = it.mask_len;
    beat[38]      = it.has_next_hop;
    beat[70:39]   = it.next_hop_addr;
    beat[74:71]   = it.route_interface;
    beat[106:75]  = it.dst_addr;
    beat[114:107] = it.ttl_in;
    s_tdata  <= beat;
    s_tuser  <= it.kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    book.accept_item(it);
    items_sent++;
    @(negedge clk);
    gap = pick_gap(SIDE_SEND);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Add beat; datagram fields carry junk that the block must ignore
  task automatic send_add(input bit [31:0] pfx, input bit [5:0] len, input bit has_hop,
                          input bit [31:0] hop, input bit [3:0] ifc);
    item_t it;
    it.kind            = KIND_ADD;
    it.dest_prefix     = pfx;
    it.mask_len        = len;
    it.has_next_hop    = has_hop;
    it.next_hop_addr   = hop;
    it.route_interface = ifc;
    it.dst_addr        = $urandom;
    it.ttl_in          = 8'($urandom);
    drive_item(it);
  endtask

  // Datagram beat; route fields carry junk
  task automatic send_packet(input bit [31:0] dst, input bit [7:0] ttl);
    item_t it;
    it.kind            = KIND_DATAGRAM;
    it.dest_prefix     = $urandom;
    it.mask_len        = 6'($urandom);
    it.has_next_hop    = 1'($urandom);
    it.next_hop_addr   = $urandom;
    it.route_interface = 4'($urandom);
    it.dst_addr        = dst;
    it.ttl_in          = ttl;
    drive_item(it);
  endtask

  // Random route: mostly real lengths, some overlong, some ties on a stored prefix
  task automatic random_route();
    bit [31:0] pfx;
    bit [5:0]  len;
    int        r;
    int        i;
    pfx = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      len = 6'($urandom_range(0, 8));
    end else if (r < 75) begin
      len = 6'($urandom_range(9, 32));
    end else if (r < 87) begin
      len = 6'($urandom_range(33, 63));
    end else if (book.route_count > 0) begin
      i = $urandom_range(0, book.route_count - 1);
      len = book.length_tab[i];
      pfx = (book.prefix_tab[i] & book.prefix_mask(len)) | (pfx & ~book.prefix_mask(len));
    end else begin
      len = 6'd24;
    end
    send_add(pfx, len, 1'($urandom), $urandom, 4'($urandom_range(0, 15)));
  endtask

  // Random datagram: most aimed inside a stored prefix, some TTL corners
  task automatic random_datagram();
    bit [31:0] dst;
    bit [31:0] m;
    bit [7:0]  ttl;
    int        r;
    int        i;
    dst = $urandom;
    if (book.route_count > 0 && $urandom_range(0, 99) < 65) begin
      i = $urandom_range(0, book.route_count - 1);
      m = book.prefix_mask(book.length_tab[i]);
      dst = (book.prefix_tab[i] & m) | (dst & ~m);
    end
    r = $urandom_range(0, 99);
    if (r < 8) ttl = 8'($urandom_range(0, 1));
    else if (r < 12) ttl = 8'd2;
    else if (r < 15) ttl = 8'd255;
    else ttl = 8'($urandom_range(2, 255));
    send_packet(dst, ttl);
  endtask

  // Result side: ready bursts and stalls, one long hold-off to back up the input
  initial begin
    bit held;
    int stall;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = pick_gap(SIDE_RECV);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  // Check every result beat as it is taken
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      book.check_result(m_tdata);
  end

  // Stimulus: directed corners first, then random traffic
  initial begin
    book = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_packet(32'h0A01_0203, 8'd64);                           // empty table: no route
    send_packet(32'h0A01_0203, 8'd0);                            // TTL zero
    send_packet(32'h0A01_0203, 8'd1);                            // TTL one
    send_add(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 4'd3);
    send_packet(32'h0A01_0203, 8'd255);                          // via next hop
    send_packet(32'h0B00_0001, 8'd2);                            // no route
    send_add(32'h0A01_0000, 6'd16, 1'b0, 32'hFFFF_FFFF, 4'd0);   // direct route
    send_packet(32'h0A01_C807, 8'd2);                            // /16 beats /8, TTL to one
    send_add(32'h0A01_0000, 6'd16, 1'b1, 32'hFFFF_FFFF, 4'd15);  // same length, added later
    send_packet(32'h0A01_0000, 8'd100);                          // earliest route wins tie
    send_add(32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0000_0000, 4'd15);  // overlong length
    send_packet(32'hFFFF_FFFF, 8'd9);
    send_packet(32'hFFFF_FFFE, 8'd9);                            // one bit off: no route
    send_add(32'h0000_0000, 6'd32, 1'b0, 32'h1234_5678, 4'd7);
    send_packet(32'h0000_0000, 8'd255);
    send_add(32'hDEAD_BEEF, 6'd0, 1'b1, 32'hC0A8_0001, 4'd9);    // default route
    send_packet(32'hFFFF_FFFE, 8'd3);
    send_packet(32'h0B00_0001, 8'd128);
    send_add(32'h0A80_0000, 6'd33, 1'b0, 32'h0, 4'd5);           // overlong, stored as /32
    send_packet(32'h0A80_0000, 8'd1);                            // TTL one: dropped without a scan
    send_packet(32'h0A80_0000, 8'd50);
    send_add(32'h8000_0000, 6'd1, 1'b1, 32'hFEDC_BA98, 4'd1);
    send_packet(32'h8000_0001, 8'd200);                          // /1 beats the default

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 12) random_route();
      else random_datagram();
    end
    s_tvalid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lpm_pkg.sv
hdl/lpm_ctrl.sv
hdl/lpm_datapath.sv
hdl/longest_prefix_match_router.sv
verif/longest_prefix_match_router_tb.sv
